[rtl/mfcw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfcw_pkg
// shared types and constants of the clipped-window median filter
// ----------------------------------------------------------------------------
package mfcw_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_RADIUS = 2;
  localparam int MAX_HEIGHT     = 1024;
  localparam int ROW_W          = 10;
  localparam int CFG_W          = 11;
  localparam int RAD_W          = 2;
  localparam int PIX_W          = 8;
  localparam int IDX_W          = 2;

  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [IDX_W-1:0] REG_WINDOW_RADIUS = 2'd2;

  localparam logic [CFG_W-1:0] RESET_WIDTH  = 11'd512;
  localparam logic [CFG_W-1:0] RESET_HEIGHT = 11'd512;
  localparam logic [RAD_W-1:0] RESET_RADIUS = 2'd1;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef struct packed {
    logic             cmd;
    logic [PIX_W-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             frame_last;
  } out_item_t;

  typedef struct packed {
    logic s2_load;
    logic out_load;
  } pipe_en_t;

endpackage

[rtl/mfcw_line_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfcw_line_ram
// one line store bank copy: one write port, one registered write-first read
// ----------------------------------------------------------------------------
module mfcw_line_ram #(
  parameter int DEPTH = mfcw_pkg::DEF_MAX_WIDTH
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   wa,
  input  logic [mfcw_pkg::PIX_W-1:0] wd,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   ra,
  output logic [mfcw_pkg::PIX_W-1:0] rd
);

  logic [mfcw_pkg::PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd <= (we && (wa == ra)) ? wd : mem[ra];
    end
  end

endmodule

[rtl/mfcw_median.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfcw_median
// rank counting stage and lower median select into the output register
// ----------------------------------------------------------------------------
module mfcw_median #(
  parameter int WN = 25
) (
  input  logic                       clk,
  input  mfcw_pkg::pipe_en_t         en,
  input  logic [mfcw_pkg::PIX_W-1:0] vals [WN],
  input  logic [WN-1:0]              mask,
  input  logic                       last,
  output mfcw_pkg::out_item_t        res
);

  localparam int CNTW = $clog2(WN + 1);

  logic [CNTW-1:0]            lt_cnt [WN];
  logic [CNTW-1:0]            le_cnt [WN];
  logic [CNTW-1:0]            k_cnt;
  logic [mfcw_pkg::PIX_W-1:0] s2_vals [WN];
  logic [CNTW-1:0]            s2_lt [WN];
  logic [CNTW-1:0]            s2_le [WN];
  logic [WN-1:0]              s2_mask;
  logic [CNTW-1:0]            s2_k;
  logic                       s2_last;
  logic [mfcw_pkg::PIX_W-1:0] med;

  always_comb begin
    logic [WN-1:0] lt_bits;
    logic [WN-1:0] le_bits;
    for (int e = 0; e < WN; e++) begin
      for (int f = 0; f < WN; f++) begin
        lt_bits[f] = mask[f] && (vals[f] < vals[e]);
        le_bits[f] = mask[f] && (vals[f] <= vals[e]);
      end
      lt_cnt[e] = CNTW'($countones(lt_bits));
      le_cnt[e] = CNTW'($countones(le_bits));
    end
    k_cnt = CNTW'(($countones(mask) - 1) >> 1);
  end

  always_ff @(posedge clk) begin
    if (en.s2_load) begin
      s2_vals <= vals;
      s2_lt   <= lt_cnt;
      s2_le   <= le_cnt;
      s2_mask <= mask;
      s2_k    <= k_cnt;
      s2_last <= last;
    end
  end

  // every selected entry carries the same value
  always_comb begin
    med = '0;
    for (int e = 0; e < WN; e++) begin
      if (s2_mask[e] && (s2_lt[e] <= s2_k) && (s2_le[e] > s2_k)) begin
        med = med | s2_vals[e];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.out_load) begin
      res.pixel_out  <= med;
      res.frame_last <= s2_last;
    end
  end

endmodule

[rtl/median_filter_clipped_window_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_filter_clipped_window_unit
// lower median of a clipped square window over a raster pixel stream
// ----------------------------------------------------------------------------
// One transaction (pixel or flush) is taken every clock while in_stall is
// low. A transaction that makes a window complete reaches the output
// register in these steps: line store read at its accepting edge, rank
// counting over all window pairs, median select into the output register.
// Each of the 2*MAX_RADIUS+2 row banks is kept in 2*MAX_RADIUS+1
// copies so a whole window is read in one access; the line store needs no
// clearing after reset. Register writes restart the frame.
module median_filter_clipped_window_unit #(
  parameter int MAX_WIDTH  = mfcw_pkg::DEF_MAX_WIDTH,
  parameter int MAX_RADIUS = mfcw_pkg::DEF_MAX_RADIUS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  mfcw_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output mfcw_pkg::out_item_t        out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [mfcw_pkg::IDX_W-1:0] cfg_index,
  input  logic [mfcw_pkg::CFG_W-1:0] cfg_data
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int CW1  = CW + 1;
  localparam int LW   = (CW1 > mfcw_pkg::CFG_W) ? CW1 : mfcw_pkg::CFG_W;
  localparam int RW   = mfcw_pkg::ROW_W;
  localparam int ST   = 2 * MAX_RADIUS + 2;
  localparam int WS   = 2 * MAX_RADIUS + 1;
  localparam int WN   = WS * WS;
  localparam int BW   = $clog2(ST);
  localparam int TW   = $clog2(3 * ST);
  localparam int RDW  = $clog2(MAX_RADIUS + 1);

  logic [mfcw_pkg::CFG_W-1:0] img_width;
  logic [mfcw_pkg::CFG_W-1:0] img_height;
  logic [mfcw_pkg::RAD_W-1:0] win_radius;
  logic [RW-1:0]              in_row;
  logic [CW-1:0]              in_col;
  logic [BW-1:0]              in_bank;
  logic                       in_done;
  logic [RW-1:0]              out_row;
  logic [CW-1:0]              out_col;
  logic [BW-1:0]              out_bank;

  logic [RW-1:0]              in_row_next;
  logic [CW-1:0]              in_col_next;
  logic [BW-1:0]              in_bank_next;
  logic                       in_done_next;

  logic [CW-1:0]              wm1;
  logic [RW-1:0]              hm1;
  logic [RDW-1:0]             rad;
  logic [LW-1:0]              w_ext;

  logic                       in_acc;
  logic                       pix_we;
  logic                       cfg_we;
  logic                       win_ready;
  logic                       emit;
  logic                       pos_last;
  logic [RW-1:0]              nr;
  logic [CW-1:0]              nc;
  logic [RW:0]                nr_sum;
  logic [CW:0]                nc_sum;

  logic [WS-1:0]              colv;
  logic [WS-1:0]              rowv;
  logic [CW-1:0]              col_addr [WS];
  logic [BW-1:0]              row_bank [WS];
  logic [WN-1:0]              mask;

  logic                       s1_valid;
  logic [WN-1:0]              s1_mask;
  logic                       s1_last;
  logic [BW-1:0]              s1_bank [WS];
  logic                       s2_valid;

  logic                       out_free;
  logic                       s2_canload;
  logic                       s1_canload;
  mfcw_pkg::pipe_en_t         pipe_en;

  logic [mfcw_pkg::PIX_W-1:0] bank_rd [ST][WS];
  logic [mfcw_pkg::PIX_W-1:0] win_vals [WN];

  // effective frame geometry
  assign w_ext = LW'(img_width);

  always_comb begin
    if (img_width == '0) begin
      wm1 = '0;
    end else if (w_ext > LW'(MAX_WIDTH)) begin
      wm1 = CW'(MAX_WIDTH - 1);
    end else begin
      wm1 = CW'(w_ext - LW'(1));
    end
    if (img_height == '0) begin
      hm1 = '0;
    end else if (img_height > mfcw_pkg::CFG_W'(mfcw_pkg::MAX_HEIGHT)) begin
      hm1 = RW'(mfcw_pkg::MAX_HEIGHT - 1);
    end else begin
      hm1 = RW'(img_height - mfcw_pkg::CFG_W'(1));
    end
    if (win_radius == '0) begin
      rad = RDW'(1);
    end else if (win_radius > mfcw_pkg::RAD_W'(MAX_RADIUS)) begin
      rad = RDW'(MAX_RADIUS);
    end else begin
      rad = RDW'(win_radius);
    end
  end

  // pipeline handshake
  assign out_free   = !out_valid || !out_stall;
  assign s2_canload = !s2_valid || out_free;
  assign s1_canload = !s1_valid || s2_canload;
  assign in_stall   = !s1_canload;
  assign in_acc     = in_valid && s1_canload;
  assign cfg_ready  = 1'b1;
  assign cfg_we     = cfg_valid && cfg_ready;
  assign pix_we     = in_acc && (in_data.cmd == mfcw_pkg::CMD_PIXEL) && !in_done;

  assign pipe_en.s2_load  = s2_canload && s1_valid;
  assign pipe_en.out_load = out_free && s2_valid;

  // input position after this transaction
  always_comb begin
    in_row_next  = in_row;
    in_col_next  = in_col;
    in_bank_next = in_bank;
    in_done_next = in_done;
    if (pix_we) begin
      if (in_col >= wm1) begin
        in_col_next = '0;
        if (in_row >= hm1) begin
          in_row_next  = '0;
          in_bank_next = '0;
          in_done_next = 1'b1;
        end else begin
          in_row_next  = in_row + RW'(1);
          in_bank_next = (in_bank == BW'(ST - 1)) ? '0 : in_bank + BW'(1);
        end
      end else begin
        in_col_next = in_col + CW'(1);
      end
    end
  end

  // window completeness
  always_comb begin
    nr_sum    = {1'b0, out_row} + (RW + 1)'(rad);
    nc_sum    = {1'b0, out_col} + (CW + 1)'(rad);
    nr        = (nr_sum > {1'b0, hm1}) ? hm1 : nr_sum[RW-1:0];
    nc        = (nc_sum > {1'b0, wm1}) ? wm1 : nc_sum[CW-1:0];
    win_ready = in_done_next || (in_row_next > nr) ||
                ((in_row_next == nr) && (in_col_next > nc));
    emit      = in_acc && win_ready;
    pos_last  = (out_row >= hm1) && (out_col >= wm1);
  end

  // window rows, columns and their banks
  always_comb begin
    logic [CW:0]   u;
    logic [RW:0]   y;
    logic [TW-1:0] t;
    for (int j = 0; j < WS; j++) begin
      u           = CW1'(out_col) + CW1'(j);
      colv[j]     = (CW1'(j) <= CW1'({rad, 1'b0})) && (u >= CW1'(rad)) &&
                    ((u - CW1'(rad)) <= CW1'(wm1));
      col_addr[j] = colv[j] ? CW'(u - CW1'(rad)) : '0;
    end
    for (int i = 0; i < WS; i++) begin
      y       = (RW + 1)'(out_row) + (RW + 1)'(i);
      rowv[i] = ((RW + 1)'(i) <= (RW + 1)'({rad, 1'b0})) && (y >= (RW + 1)'(rad)) &&
                ((y - (RW + 1)'(rad)) <= (RW + 1)'(hm1));
      t       = TW'(out_bank) + TW'(ST) + TW'(i) - TW'(rad);
      if (t >= TW'(2 * ST)) begin
        t = t - TW'(2 * ST);
      end else if (t >= TW'(ST)) begin
        t = t - TW'(ST);
      end
      row_bank[i] = BW'(t);
    end
    for (int i = 0; i < WS; i++) begin
      for (int j = 0; j < WS; j++) begin
        mask[i * WS + j] = rowv[i] && colv[j];
      end
    end
  end

  // configuration and position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      img_width  <= mfcw_pkg::RESET_WIDTH;
      img_height <= mfcw_pkg::RESET_HEIGHT;
      win_radius <= mfcw_pkg::RESET_RADIUS;
      in_row     <= '0;
      in_col     <= '0;
      in_bank    <= '0;
      in_done    <= 1'b0;
      out_row    <= '0;
      out_col    <= '0;
      out_bank   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        mfcw_pkg::REG_IMAGE_WIDTH: begin
          img_width <= cfg_data;
        end
        mfcw_pkg::REG_IMAGE_HEIGHT: begin
          img_height <= cfg_data;
        end
        mfcw_pkg::REG_WINDOW_RADIUS: begin
          win_radius <= cfg_data[mfcw_pkg::RAD_W-1:0];
        end
        default: begin
        end
      endcase
      if ((cfg_index == mfcw_pkg::REG_IMAGE_WIDTH) ||
          (cfg_index == mfcw_pkg::REG_IMAGE_HEIGHT) ||
          (cfg_index == mfcw_pkg::REG_WINDOW_RADIUS)) begin
        in_row   <= '0;
        in_col   <= '0;
        in_bank  <= '0;
        in_done  <= 1'b0;
        out_row  <= '0;
        out_col  <= '0;
        out_bank <= '0;
      end
    end else if (emit && pos_last) begin
      in_row   <= '0;
      in_col   <= '0;
      in_bank  <= '0;
      in_done  <= 1'b0;
      out_row  <= '0;
      out_col  <= '0;
      out_bank <= '0;
    end else begin
      in_row  <= in_row_next;
      in_col  <= in_col_next;
      in_bank <= in_bank_next;
      in_done <= in_done_next;
      if (emit) begin
        if (out_col >= wm1) begin
          out_col  <= '0;
          out_row  <= out_row + RW'(1);
          out_bank <= (out_bank == BW'(ST - 1)) ? '0 : out_bank + BW'(1);
        end else begin
          out_col <= out_col + CW'(1);
        end
      end
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= s2_valid;
      end
      if (s2_canload) begin
        s2_valid <= s1_valid;
      end
      if (s1_canload) begin
        s1_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mask <= mask;
      s1_last <= pos_last;
      s1_bank <= row_bank;
    end
  end

  // line store banks
  for (genvar b = 0; b < ST; b++) begin : g_bank
    for (genvar j = 0; j < WS; j++) begin : g_copy
      mfcw_line_ram #(
        .DEPTH(MAX_WIDTH)
      ) u_ram (
        .clk(clk),
        .we (pix_we && (in_bank == BW'(b))),
        .wa (in_col),
        .wd (in_data.pixel_in),
        .re (in_acc),
        .ra (col_addr[j]),
        .rd (bank_rd[b][j])
      );
    end
  end

  always_comb begin
    for (int i = 0; i < WS; i++) begin
      for (int j = 0; j < WS; j++) begin
        win_vals[i * WS + j] = bank_rd[s1_bank[i]][j];
      end
    end
  end

  mfcw_median #(
    .WN(WN)
  ) u_median (
    .clk (clk),
    .en  (pipe_en),
    .vals(win_vals),
    .mask(s1_mask),
    .last(s1_last),
    .res (out_data)
  );

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && s2_valid && out_valid))
    else $error("input stalled with a free stage");

  a_counters_in_frame: assert property (@(posedge clk) disable iff (rst)
    (in_col <= wm1) && (out_col <= wm1) && (in_row <= hm1) && (out_row <= hm1))
    else $error("position counter outside frame");

  a_window_not_empty: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (s1_mask != '0))
    else $error("empty window in flight");

  a_output_not_ahead: assert property (@(posedge clk) disable iff (rst)
    (!in_done && (in_row == '0) && (in_col == '0)) |-> ((out_row == '0) && (out_col == '0)))
    else $error("output position ahead of input");
`endif

endmodule
